// File: rtl/aus_pkg.sv
// Shared types and constants of the H.264 access unit splitter.
package aus_pkg;

  // Default length of the byte delay line.
  localparam int DelayDepthDef = 8;

  // Most words that one end-of-stream flush delivers.
  localparam int MaxResults = 8;
  localparam int FlushCntW  = $clog2(MaxResults + 1);

  // Start code and NAL header constants.
  localparam logic [7:0] CodeZero       = 8'h00;
  localparam logic [7:0] CodeOne        = 8'h01;
  localparam logic [4:0] NalSliceNonIdr = 5'd1;
  localparam logic [4:0] NalSliceIdr    = 5'd5;
  localparam logic [4:0] NalSei         = 5'd6;
  localparam logic [4:0] NalSps         = 5'd7;
  localparam logic [4:0] NalPps         = 5'd8;
  localparam int         FirstMbBit     = 7;
  localparam logic [1:0] CountMax       = 2'd3;

  // Configuration register indexes.
  localparam logic RegHeaderSplit = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_start;
    logic       run_last;
  } out_word_t;

  // Scanner decisions for the delay line, valid in the cycle a word is accepted.
  typedef struct packed {
    logic       mark;
    logic       started_before;
    logic       started_after;
    logic [2:0] code_offset;
  } scan_ctl_t;

endpackage

// File: rtl/aus_scan.sv
// Start code scanner and access unit cut rules.
module aus_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  aus_pkg::in_word_t    in_data_i,
  input  logic                 header_split_i,
  output aus_pkg::scan_ctl_t   ctl_o
);
  import aus_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhZ1    = 3'd1;
  localparam logic [2:0] PhZ2    = 3'd2;
  localparam logic [2:0] PhZ3    = 3'd3;
  localparam logic [2:0] PhType  = 3'd4;
  localparam logic [2:0] PhSlice = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [2:0] offset_q, offset_d;
  logic [1:0] hdr_cnt_q, hdr_cnt_d;
  logic [1:0] slc_cnt_q, slc_cnt_d;
  logic       seeking_q, seeking_d;
  logic       started_q, started_d;
  logic       last_slice_q, last_slice_d;
  logic       mark;

  function automatic logic [1:0] sat_inc(logic [1:0] v);
    return (v < CountMax) ? v + 2'd1 : CountMax;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [4:0] nal;
    logic       ev_hdr;
    logic       ev_slice;
    logic       cut;
    b            = in_data_i.data_byte;
    nal          = b[4:0];
    ev_hdr       = 1'b0;
    ev_slice     = 1'b0;
    cut          = 1'b0;
    mark         = 1'b0;
    phase_d      = phase_q;
    offset_d     = offset_q;
    hdr_cnt_d    = hdr_cnt_q;
    slc_cnt_d    = slc_cnt_q;
    seeking_d    = seeking_q;
    started_d    = started_q;
    last_slice_d = last_slice_q;

    if (accept_i) begin
      if (in_data_i.end_of_stream) begin
        // No start code spans a flush.
        phase_d  = PhIdle;
        offset_d = 3'd0;
      end else begin
        unique case (phase_q)
          PhIdle: begin
            if (b == CodeZero) begin
              phase_d  = PhZ1;
              offset_d = 3'd0;
            end
          end
          PhZ1: begin
            offset_d = offset_q + 3'd1;
            phase_d  = (b == CodeZero) ? PhZ2 : PhIdle;
          end
          PhZ2: begin
            offset_d = offset_q + 3'd1;
            if (b == CodeZero) begin
              phase_d = PhZ3;
            end else if (b == CodeOne) begin
              phase_d = PhType;
            end else begin
              phase_d = PhIdle;
            end
          end
          PhZ3: begin
            // Extra leading zeros stay with the previous unit, so the code start
            // moves forward and the offset holds.
            if (b != CodeZero) begin
              offset_d = offset_q + 3'd1;
              phase_d  = (b == CodeOne) ? PhType : PhIdle;
            end
          end
          PhType: begin
            offset_d = offset_q + 3'd1;
            if (nal == NalSliceNonIdr || nal == NalSliceIdr) begin
              phase_d = PhSlice;
            end else begin
              phase_d = PhIdle;
              ev_hdr  = (nal == NalSei) || (nal == NalSps) || (nal == NalPps);
            end
          end
          PhSlice: begin
            offset_d = offset_q + 3'd1;
            ev_slice = b[FirstMbBit];
            phase_d  = PhIdle;
          end
          default: phase_d = PhIdle;
        endcase

        if (ev_hdr || ev_slice) begin
          if (ev_slice) begin
            slc_cnt_d    = sat_inc(slc_cnt_d);
            last_slice_d = 1'b1;
          end else begin
            hdr_cnt_d    = sat_inc(hdr_cnt_d);
            last_slice_d = 1'b0;
          end
          if (header_split_i && hdr_cnt_d != 2'd0 && slc_cnt_d == 2'd1) begin
            cut = 1'b1;
          end else begin
            if (!started_d && hdr_cnt_d == 2'd1 && slc_cnt_d == 2'd0) begin
              mark      = 1'b1;
              started_d = 1'b1;
            end
            if (!started_d && hdr_cnt_d == 2'd0 && slc_cnt_d == 2'd1) begin
              mark      = 1'b1;
              started_d = 1'b1;
              seeking_d = 1'b1;
              hdr_cnt_d = 2'd0;
              slc_cnt_d = 2'd0;
            end
            if (!seeking_d && hdr_cnt_d != 2'd0 && slc_cnt_d == 2'd1) begin
              seeking_d = 1'b1;
              hdr_cnt_d = 2'd0;
              slc_cnt_d = 2'd0;
            end
            if (seeking_d && (hdr_cnt_d != 2'd0 || slc_cnt_d != 2'd0)) begin
              cut = 1'b1;
            end
          end
          if (cut) begin
            mark      = 1'b1;
            started_d = 1'b1;
            slc_cnt_d = 2'd0;
            if (last_slice_d) begin
              seeking_d = 1'b1;
              hdr_cnt_d = 2'd0;
            end else begin
              seeking_d = 1'b0;
              hdr_cnt_d = 2'd1;
            end
          end
        end
      end
    end
  end

  assign ctl_o.mark           = mark;
  assign ctl_o.started_before = started_q;
  assign ctl_o.started_after  = started_d;
  assign ctl_o.code_offset    = offset_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      offset_q     <= 3'd0;
      hdr_cnt_q    <= 2'd0;
      slc_cnt_q    <= 2'd0;
      seeking_q    <= 1'b0;
      started_q    <= 1'b0;
      last_slice_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      offset_q     <= offset_d;
      hdr_cnt_q    <= hdr_cnt_d;
      slc_cnt_q    <= slc_cnt_d;
      seeking_q    <= seeking_d;
      started_q    <= started_d;
      last_slice_q <= last_slice_d;
    end
  end

endmodule

// File: rtl/aus_delay.sv
// Byte delay line with unit start marks, flush drain and output register.
module aus_delay #(
  parameter int DelayDepth = aus_pkg::DelayDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aus_pkg::in_word_t   in_data_i,
  input  aus_pkg::scan_ctl_t  ctl_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aus_pkg::out_word_t  out_data_o
);
  import aus_pkg::*;

  localparam int HeldW = $clog2(DelayDepth + 1);
  localparam int IdxW  = $clog2(DelayDepth);

  logic [7:0]           data_q [DelayDepth];
  logic [7:0]           data_d [DelayDepth];
  logic                 mark_q [DelayDepth];
  logic                 mark_d [DelayDepth];
  logic [HeldW-1:0]     held_q, held_d;
  logic                 flushing_q, flushing_d;
  logic [FlushCntW-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;
  logic                 out_free;
  logic                 accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !flushing_q && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0]       ins_data [DelayDepth];
    logic             ins_mark [DelayDepth];
    logic [7:0]       a_data [DelayDepth];
    logic             a_mark [DelayDepth];
    logic [HeldW-1:0] held1;
    logic [HeldW-1:0] held2;
    logic [HeldW-1:0] code_back;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  drop_n;
    logic [HeldW:0]   src;
    data_d      = data_q;
    mark_d      = mark_q;
    held_d      = held_q;
    flushing_d  = flushing_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ins_data    = data_q;
    ins_mark    = mark_q;
    a_data      = data_q;
    a_mark      = mark_q;
    held1       = held_q + HeldW'(1);
    held2       = held1;
    code_back   = '0;
    idx         = '0;
    drop_n      = '0;
    src         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (flushing_q) begin
      if (out_free) begin
        out_valid_d      = 1'b1;
        out_d.out_byte   = data_q[0];
        out_d.unit_start = mark_q[0];
        out_d.run_last   = (cnt_q == FlushCntW'(1));
        for (int i = 0; i < DelayDepth - 1; i++) begin
          data_d[i] = data_q[i+1];
          mark_d[i] = mark_q[i+1];
        end
        held_d = held_q - HeldW'(1);
        cnt_d  = cnt_q - FlushCntW'(1);
        if (cnt_q == FlushCntW'(1)) begin
          flushing_d = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_data_i.end_of_stream) begin
        // Before the first unit there is nothing to deliver.
        if (!ctl_i.started_before) begin
          held_d = '0;
        end else if (held_q != '0) begin
          flushing_d = 1'b1;
          cnt_d = (int'(held_q) > MaxResults) ? FlushCntW'(MaxResults) : FlushCntW'(held_q);
        end
      end else begin
        for (int i = 0; i < DelayDepth; i++) begin
          if (HeldW'(i) == held_q) begin
            ins_data[i] = in_data_i.data_byte;
            ins_mark[i] = 1'b0;
          end
        end

        // Entry holding the first zero of the current start code.
        if (HeldW'(ctl_i.code_offset) < held1) begin
          code_back = held1 - HeldW'(1) - HeldW'(ctl_i.code_offset);
          idx       = code_back[IdxW-1:0];
        end
        if (ctl_i.mark && !ctl_i.started_before) begin
          drop_n = idx;
        end

        // The first unit starts here: older bytes are dropped.
        a_data = ins_data;
        a_mark = ins_mark;
        for (int i = 0; i < DelayDepth; i++) begin
          src = (HeldW+1)'(i) + (HeldW+1)'(drop_n);
          if (src < (HeldW+1)'(DelayDepth)) begin
            a_data[i] = ins_data[src[IdxW-1:0]];
            a_mark[i] = ins_mark[src[IdxW-1:0]];
          end
        end
        held2 = held1 - HeldW'(drop_n);
        if (ctl_i.mark) begin
          if (ctl_i.started_before) begin
            a_mark[idx] = 1'b1;
          end else begin
            a_mark[0] = 1'b1;
          end
        end

        if (held2 == HeldW'(DelayDepth)) begin
          if (ctl_i.started_after) begin
            out_valid_d      = 1'b1;
            out_d.out_byte   = a_data[0];
            out_d.unit_start = a_mark[0];
            out_d.run_last   = 1'b1;
          end
          for (int i = 0; i < DelayDepth - 1; i++) begin
            data_d[i] = a_data[i+1];
            mark_d[i] = a_mark[i+1];
          end
          data_d[DelayDepth-1] = a_data[DelayDepth-1];
          mark_d[DelayDepth-1] = a_mark[DelayDepth-1];
          held_d = HeldW'(DelayDepth - 1);
        end else begin
          data_d = a_data;
          mark_d = a_mark;
          held_d = held2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      flushing_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      flushing_q  <= flushing_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    mark_q <= mark_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Between accepted bytes the line always has room for one more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < HeldW'(DelayDepth))
    else $error("delay line overfilled");

  // A flush in progress always has words left to deliver and held bytes to take them from.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (cnt_q != '0) && (HeldW'(cnt_q) <= held_q))
    else $error("flush count out of step with the delay line");

  // Only a flush delivers words that are not the last of their input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.run_last) |-> flushing_q)
    else $error("non-final word outside a flush");

endmodule

// File: rtl/h264_access_unit_splitter.sv
// Top level of the H.264 Annex B access unit splitter.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid/in_ready     in_data  (data_byte, end_of_stream)
//   out      output     out_valid/out_ready   out_data (out_byte, unit_start, run_last)
//   config   input      APB psel/penable      header_split at byte address 0
//
// A stream byte is taken every cycle while the output register is free or being emptied;
// its result word, if any, appears in the output register on the next cycle.
// An end-of-stream word delivers up to eight held bytes, one per cycle, from the delay
// line; no input word is taken until the last of them is loaded into the output register.
// Reset clears the scanner, the unit state, the fill count and the output valid.
// A stall on the output holds the result word and stops input acceptance and any flush.
module h264_access_unit_splitter #(
  parameter int DelayDepth = aus_pkg::DelayDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aus_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aus_pkg::out_word_t out_data_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);
  import aus_pkg::*;

  logic      header_split_q;
  logic      accept;
  scan_ctl_t ctl;

  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_split_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == RegHeaderSplit)) begin
      header_split_q <= pwdata_i[0];
    end
  end

  assign prdata_o = (paddr_i[2] == RegHeaderSplit) ? {31'd0, header_split_q} : 32'd0;

  assign accept = in_valid_i && in_ready_o;

  aus_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_data_i      (in_data_i),
    .header_split_i (header_split_q),
    .ctl_o          (ctl)
  );

  aus_delay #(
    .DelayDepth (DelayDepth)
  ) u_delay (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
